/* sv/lmf_pkg.sv */
package lmf_pkg;

  // Configuration register: matrix size.
  localparam int CFG_W      = 5;
  localparam int SIZE_RESET = 16;
  localparam int MIN_SIZE   = 2;

  // Fixed widths of the running totals.
  localparam int COUNT_W = 9;
  localparam int SUM_W   = 22;

  // One sample can complete at most four neighborhoods.
  localparam int RES_MAX   = 4;
  localparam int RES_IDX_W = $clog2(RES_MAX);

endpackage

/* sv/local_minimum_finder_3x3.sv */
// Local minimum finder over a square matrix of signed samples streamed in
// raster order. Each element is flagged when it is strictly smaller than all
// of its existing neighbors in the 3x3 neighborhood (border neighbors are
// left out), and every result also carries the running minima count and the
// running sum of absolute values above the main diagonal; frame_last marks
// the final result of a frame, whose totals are complete. One sample is
// taken per clock while in_stall_o is low. A sample that completes one
// neighborhood (or none, on the first row and column) holds the input only
// if the output stalls; one in the last column or row completes two, the
// frame's last sample four, and these hold the input until the single
// output register, draining one result per cycle while out_stall_i is low,
// has taken all but the last. Results pass pending and output registers.
// The line buffers are shift chains of MAX_SIZE cells with no clearing
// pass. Write matrix_size only while idle; a write restarts the frame.
module local_minimum_finder_3x3 import lmf_pkg::*; #(
  parameter int MAX_SIZE     = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [CFG_W-1:0]                  cfg_matrix_size_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic signed [SAMPLE_WIDTH-1:0]    sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [$clog2(MAX_SIZE)-1:0]       row_o,
  output logic [$clog2(MAX_SIZE)-1:0]       column_o,
  output logic signed [SAMPLE_WIDTH-1:0]    centre_value_o,
  output logic                              is_minimum_o,
  output logic [COUNT_W-1:0]                minimum_count_o,
  output logic [SUM_W-1:0]                  upper_sum_o,
  output logic                              frame_last_o
);

  localparam int SW    = SAMPLE_WIDTH;
  localparam int POS_W = $clog2(MAX_SIZE);
  localparam int NW    = POS_W + 1;
  localparam int CW    = (NW > CFG_W) ? NW : CFG_W;
  localparam int RW    = 2 * POS_W + SW + 1 + COUNT_W + SUM_W + 1;

  localparam logic [1:0] CR [RES_MAX] = '{2'd1, 2'd1, 2'd2, 2'd2};
  localparam logic [1:0] CC [RES_MAX] = '{2'd1, 2'd2, 2'd1, 2'd2};

  logic [CFG_W-1:0]   size_q;
  logic [POS_W-1:0]   row_q, row_d;
  logic [POS_W-1:0]   col_q, col_d;
  logic [COUNT_W-1:0] minima_q, minima_d;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic signed [SW-1:0] w1_q [3];
  logic signed [SW-1:0] w2_q [3];

  logic [CW-1:0]    size_ext;
  logic [CW-1:0]    size_clamped;
  logic [NW-1:0]    size_n;
  logic [POS_W-1:0] last_idx;

  logic accept;
  logic cfg_write;
  logic queue_full;
  logic frame_end;
  logic top_ok;
  logic left_ok;

  logic [SW-1:0]          above;
  logic [SW-1:0]          two_above;
  logic signed [SW-1:0]   win [3][3];
  logic [SUM_W+SW-1:0]    sample_ext;
  logic [SUM_W+SW-1:0]    abs_wide;

  logic [1:0]             rlo [RES_MAX];
  logic [1:0]             clo [RES_MAX];
  logic [RES_MAX-1:0]     jvalid;
  logic [RES_MAX-1:0]     jmin;
  logic [POS_W-1:0]       jrow [RES_MAX];
  logic [POS_W-1:0]       jcol [RES_MAX];
  logic [COUNT_W-1:0]     jcnt [RES_MAX];
  logic [RES_MAX-1:0][RW-1:0] res_data;
  logic [RW-1:0]          out_data;

  // Size in use: clamped to the range the hardware supports.
  always_comb begin
    size_ext = CW'(size_q);
    if (size_ext < CW'(MIN_SIZE)) begin
      size_clamped = CW'(MIN_SIZE);
    end else if (size_ext > CW'(MAX_SIZE)) begin
      size_clamped = CW'(MAX_SIZE);
    end else begin
      size_clamped = size_ext;
    end
  end

  assign size_n   = size_clamped[NW-1:0];
  assign last_idx = POS_W'(size_n - NW'(1));

  assign cfg_ready_o = 1'b1;
  assign cfg_write   = cfg_valid_i && cfg_ready_o;
  assign in_stall_o  = queue_full;
  assign accept      = in_valid_i && !in_stall_o;

  lmf_line_buffer #(
    .MAX_SIZE    (MAX_SIZE),
    .SAMPLE_WIDTH(SW)
  ) u_line_buffer (
    .clk_i      (clk_i),
    .shift_i    (accept),
    .size_i     (size_n),
    .sample_i   (sample_i),
    .above_o    (above),
    .two_above_o(two_above)
  );

  // Window as seen after this sample: two held columns plus the new one.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win[r][0] = w1_q[r];
      win[r][1] = w2_q[r];
    end
    win[0][2] = $signed(two_above);
    win[1][2] = $signed(above);
    win[2][2] = sample_i;
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int r = 0; r < 3; r++) begin
        w1_q[r] <= w2_q[r];
        w2_q[r] <= win[r][2];
      end
    end
  end

  assign frame_end = (row_q == last_idx) && (col_q == last_idx);
  assign top_ok    = row_q > POS_W'(1);
  assign left_ok   = col_q > POS_W'(1);

  // The four neighborhoods this sample may complete, in raster order:
  // up-left, up, left, and the sample itself at the end of a frame.
  always_comb begin
    jvalid[0] = (row_q != '0) && (col_q != '0);
    jvalid[1] = (row_q != '0) && (col_q == last_idx);
    jvalid[2] = (row_q == last_idx) && (col_q != '0);
    jvalid[3] = frame_end;
    rlo[0] = top_ok ? 2'd0 : 2'd1;
    rlo[1] = top_ok ? 2'd0 : 2'd1;
    rlo[2] = 2'd1;
    rlo[3] = 2'd1;
    clo[0] = left_ok ? 2'd0 : 2'd1;
    clo[1] = 2'd1;
    clo[2] = left_ok ? 2'd0 : 2'd1;
    clo[3] = 2'd1;
    jrow[0] = row_q - POS_W'(1);
    jrow[1] = row_q - POS_W'(1);
    jrow[2] = row_q;
    jrow[3] = row_q;
    jcol[0] = col_q - POS_W'(1);
    jcol[1] = col_q;
    jcol[2] = col_q - POS_W'(1);
    jcol[3] = col_q;
  end

  always_comb begin
    for (int k = 0; k < RES_MAX; k++) begin
      jmin[k] = 1'b1;
      for (int a = 0; a < 3; a++) begin
        for (int b = 0; b < 3; b++) begin
          if ((2'(a) >= rlo[k]) && (2'(b) >= clo[k]) &&
              !((2'(a) == CR[k]) && (2'(b) == CC[k]))) begin
            if (!(win[CR[k]][CC[k]] < win[a][b])) begin
              jmin[k] = 1'b0;
            end
          end
        end
      end
    end
  end

  // Running count as each result would see it.
  always_comb begin
    minima_d = minima_q;
    for (int k = 0; k < RES_MAX; k++) begin
      if (jvalid[k] && jmin[k]) begin
        minima_d = minima_d + COUNT_W'(1);
      end
      jcnt[k] = minima_d;
    end
  end

  assign sample_ext = {{SUM_W{sample_i[SW-1]}}, sample_i};
  assign abs_wide   = sample_i[SW-1] ? (~sample_ext + (SUM_W+SW)'(1)) : sample_ext;
  assign sum_d      = (row_q < col_q) ? (sum_q + abs_wide[SUM_W-1:0]) : sum_q;

  always_comb begin
    for (int k = 0; k < RES_MAX; k++) begin
      res_data[k] = {jrow[k], jcol[k], win[CR[k]][CC[k]], jmin[k], jcnt[k], sum_d,
                     (k == RES_MAX - 1)};
    end
  end

  always_comb begin
    row_d = row_q;
    col_d = col_q;
    if (frame_end) begin
      row_d = '0;
      col_d = '0;
    end else if (col_q == last_idx) begin
      row_d = row_q + POS_W'(1);
      col_d = '0;
    end else begin
      col_d = col_q + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q   <= CFG_W'(SIZE_RESET);
      row_q    <= '0;
      col_q    <= '0;
      minima_q <= '0;
      sum_q    <= '0;
    end else if (cfg_write) begin
      size_q   <= cfg_matrix_size_i;
      row_q    <= '0;
      col_q    <= '0;
      minima_q <= '0;
      sum_q    <= '0;
    end else if (accept) begin
      row_q    <= row_d;
      col_q    <= col_d;
      minima_q <= frame_end ? '0 : minima_d;
      sum_q    <= frame_end ? '0 : sum_d;
    end
  end

  lmf_result_queue #(
    .RW(RW)
  ) u_result_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .load_i     (accept),
    .mask_i     (jvalid),
    .data_i     (res_data),
    .full_o     (queue_full),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data)
  );

  assign {row_o, column_o, centre_value_o, is_minimum_o, minimum_count_o, upper_sum_o,
          frame_last_o} = out_data;

`ifndef SYNTHESIS
  a_position_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (row_q <= last_idx) && (col_q <= last_idx))
    else $error("raster position outside the matrix");

  a_cfg_restarts_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_write |=> (row_q == '0) && (col_q == '0) && (minima_q == '0) && (sum_q == '0))
    else $error("configuration write did not restart the frame");

  a_frame_end_restarts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && frame_end && !cfg_write) |=>
      (row_q == '0) && (col_q == '0) && (minima_q == '0) && (sum_q == '0))
    else $error("frame totals not cleared after the last sample");
`endif

endmodule

/* sv/lmf_cell.sv */
module lmf_cell #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                    clk_i,
  input  logic                    shift_i,
  input  logic                    entry_i,
  input  logic [SAMPLE_WIDTH-1:0] prev_a_i,
  input  logic [SAMPLE_WIDTH-1:0] prev_b_i,
  input  logic [SAMPLE_WIDTH-1:0] new_a_i,
  input  logic [SAMPLE_WIDTH-1:0] new_b_i,
  output logic [SAMPLE_WIDTH-1:0] a_o,
  output logic [SAMPLE_WIDTH-1:0] b_o
);

  logic [SAMPLE_WIDTH-1:0] a_q;
  logic [SAMPLE_WIDTH-1:0] b_q;

  // The entry cell starts a new line; every other cell takes its neighbor.
  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      a_q <= entry_i ? new_a_i : prev_a_i;
      b_q <= entry_i ? new_b_i : prev_b_i;
    end
  end

  assign a_o = a_q;
  assign b_o = b_q;

endmodule

/* sv/lmf_line_buffer.sv */
module lmf_line_buffer #(
  parameter int MAX_SIZE     = 16,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                          clk_i,
  input  logic                          shift_i,
  input  logic [$clog2(MAX_SIZE):0]     size_i,
  input  logic [SAMPLE_WIDTH-1:0]       sample_i,
  output logic [SAMPLE_WIDTH-1:0]       above_o,
  output logic [SAMPLE_WIDTH-1:0]       two_above_o
);

  localparam int NW = $clog2(MAX_SIZE) + 1;

  logic [NW-1:0]           entry_idx;
  logic [SAMPLE_WIDTH-1:0] a_w [MAX_SIZE];
  logic [SAMPLE_WIDTH-1:0] b_w [MAX_SIZE];

  // Samples enter the chain so that they reach the tail after exactly
  // size_i shifts; the second line is fed from the tail of the first.
  assign entry_idx = NW'(MAX_SIZE) - size_i;

  for (genvar k = 0; k < MAX_SIZE; k++) begin : g_cell
    logic [SAMPLE_WIDTH-1:0] prev_a;
    logic [SAMPLE_WIDTH-1:0] prev_b;

    if (k == 0) begin : g_head
      assign prev_a = sample_i;
      assign prev_b = a_w[MAX_SIZE-1];
    end else begin : g_body
      assign prev_a = a_w[k-1];
      assign prev_b = b_w[k-1];
    end

    lmf_cell #(
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
    ) u_cell (
      .clk_i   (clk_i),
      .shift_i (shift_i),
      .entry_i (entry_idx == NW'(k)),
      .prev_a_i(prev_a),
      .prev_b_i(prev_b),
      .new_a_i (sample_i),
      .new_b_i (a_w[MAX_SIZE-1]),
      .a_o     (a_w[k]),
      .b_o     (b_w[k])
    );
  end

  assign above_o     = a_w[MAX_SIZE-1];
  assign two_above_o = b_w[MAX_SIZE-1];

endmodule

/* sv/lmf_result_queue.sv */
module lmf_result_queue import lmf_pkg::*; #(
  parameter int RW = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [RES_MAX-1:0]             mask_i,
  input  logic [RES_MAX-1:0][RW-1:0]     data_i,
  output logic                           full_o,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [RW-1:0]                  out_data_o
);

  logic [RES_MAX-1:0]         pend_mask_q;
  logic [RES_MAX-1:0][RW-1:0] pend_data_q;
  logic                       out_valid_q;
  logic [RW-1:0]              out_data_q;

  logic                 take;
  logic                 move;
  logic [RES_IDX_W-1:0] pick;
  logic [RES_MAX-1:0]   pend_after;

  // Lowest pending result goes first, which keeps raster order.
  always_comb begin
    pick = '0;
    for (int k = RES_MAX - 1; k >= 0; k--) begin
      if (pend_mask_q[k]) begin
        pick = RES_IDX_W'(k);
      end
    end
  end

  assign take       = !out_valid_q || !out_stall_i;
  assign move       = take && (|pend_mask_q);
  assign pend_after = move ? (pend_mask_q & ~(RES_MAX'(1) << pick)) : pend_mask_q;
  assign full_o     = |pend_after;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_mask_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      pend_mask_q <= load_i ? mask_i : pend_after;
      if (take) begin
        out_valid_q <= move;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      pend_data_q <= data_i;
    end
    if (move) begin
      out_data_q <= pend_data_q[pick];
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

`ifndef SYNTHESIS
  a_pending_blocks_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((|pend_mask_q) && !move) |-> full_o)
    else $error("request taken while earlier results are still pending");

  a_pending_reaches_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((|pend_mask_q) && !out_valid_q) |=> out_valid_q)
    else $error("pending result did not move to the output register");

  a_move_shows_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    move |=> out_valid_q)
    else $error("moved result is not presented");
`endif

endmodule
